>>> rtl/core/mce_pkg.sv
// Shared types and codes of the modular combinatorics engine.
package mce_pkg;

    // request commands
    localparam logic [2:0] CMD_POW   = 3'd0;
    localparam logic [2:0] CMD_INV   = 3'd1;
    localparam logic [2:0] CMD_FACT  = 3'd2;
    localparam logic [2:0] CMD_BINOM = 3'd3;
    localparam logic [2:0] CMD_DER   = 3'd4;
    localparam logic [2:0] CMD_CAT   = 3'd5;

    // arithmetic unit operations
    localparam logic ARITH_MUL = 1'b0;
    localparam logic ARITH_POW = 1'b1;

    typedef struct packed {
        logic        start;
        logic        op;
        logic [31:0] x;
        logic [31:0] y;
    } arith_req_t;

    typedef struct packed {
        logic        done;
        logic        busy;
        logic [30:0] result;
    } arith_rsp_t;

endpackage

>>> rtl/core/mce_if.sv
// Request, result and configuration channel interfaces.
interface mce_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    modport source (output valid, command, operand_a, operand_b, input ready);
    modport sink (input valid, command, operand_a, operand_b, output ready);
endinterface

interface mce_rsp_if;
    logic        valid;
    logic        ready;
    logic [30:0] value;
    logic        status;
    modport source (output valid, value, status, input ready);
    modport sink (input valid, value, status, output ready);
endinterface

interface mce_cfg_if;
    logic        valid;
    logic        ready;
    logic [30:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

>>> rtl/core/mce_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/core/mce_mulmod.sv
// Modular multiplier: 32x32 product, then bit-serial reduction by the modulus.
module mce_mulmod (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] x,
    input  logic [31:0] y,
    input  logic [30:0] p,
    output logic        done,
    output logic [30:0] result
);
    logic        busy_reg;
    logic [6:0]  cnt_reg;
    logic        done_reg;
    logic [63:0] prod_reg;
    logic [30:0] rem_reg;
    logic [31:0] shifted;
    logic [30:0] diff;
    logic [30:0] rem_next;

    always_comb
    begin
        shifted  = {rem_reg, prod_reg[63]};
        diff     = 31'(shifted - {1'b0, p});
        rem_next = (shifted >= {1'b0, p}) ? diff : shifted[30:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 7'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd64;
            end
            else if (busy_reg)
            begin
                if (cnt_reg != 7'd0)
                begin
                    cnt_reg <= cnt_reg - 7'd1;
                end
                else
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= x * y;
            rem_reg  <= 31'd0;
        end
        else if (busy_reg && cnt_reg != 7'd0)
        begin
            prod_reg <= {prod_reg[62:0], 1'b0};
            rem_reg  <= rem_next;
        end
    end

    assign done   = done_reg;
    assign result = rem_reg;
endmodule

>>> rtl/core/mce_arith.sv
// Arithmetic sequencer: modular product or square-and-multiply power.
module mce_arith (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [30:0]         p,
    input  mce_pkg::arith_req_t req,
    output mce_pkg::arith_rsp_t rsp
);
    import mce_pkg::*;

    localparam logic [2:0] A_IDLE = 3'd0;
    localparam logic [2:0] A_MS   = 3'd1;
    localparam logic [2:0] A_MW   = 3'd2;
    localparam logic [2:0] A_BS   = 3'd3;
    localparam logic [2:0] A_BW   = 3'd4;
    localparam logic [2:0] A_LOOP = 3'd5;
    localparam logic [2:0] A_AW   = 3'd6;
    localparam logic [2:0] A_SW   = 3'd7;

    logic [2:0]  state_reg, state_next;
    logic        done_reg, done_next;
    logic [31:0] x_reg, x_next;
    logic [31:0] y_reg, y_next;
    logic [30:0] acc_reg, acc_next;
    logic [30:0] base_reg, base_next;
    logic [30:0] res_reg, res_next;
    logic        mm_start;
    logic [31:0] mm_x, mm_y;
    logic        mm_done;
    logic [30:0] mm_res;

    mce_mulmod u_mulmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mm_start),
        .x      (mm_x),
        .y      (mm_y),
        .p      (p),
        .done   (mm_done),
        .result (mm_res)
    );

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        x_next     = x_reg;
        y_next     = y_reg;
        acc_next   = acc_reg;
        base_next  = base_reg;
        res_next   = res_reg;
        mm_start   = 1'b0;
        mm_x       = 32'd0;
        mm_y       = 32'd0;
        unique case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    x_next     = req.x;
                    y_next     = req.y;
                    acc_next   = 31'd1;
                    state_next = (req.op == ARITH_MUL) ? A_MS : A_BS;
                end
            end
            A_MS:
            begin
                mm_start   = 1'b1;
                mm_x       = x_reg;
                mm_y       = y_reg;
                state_next = A_MW;
            end
            A_MW:
            begin
                if (mm_done)
                begin
                    res_next   = mm_res;
                    done_next  = 1'b1;
                    state_next = A_IDLE;
                end
            end
            A_BS:
            begin
                // reduce the base first
                mm_start   = 1'b1;
                mm_x       = x_reg;
                mm_y       = 32'd1;
                state_next = A_BW;
            end
            A_BW:
            begin
                if (mm_done)
                begin
                    base_next  = mm_res;
                    state_next = A_LOOP;
                end
            end
            A_LOOP:
            begin
                if (y_reg == 32'd0)
                begin
                    res_next   = acc_reg;
                    done_next  = 1'b1;
                    state_next = A_IDLE;
                end
                else if (y_reg[0])
                begin
                    mm_start   = 1'b1;
                    mm_x       = {1'b0, acc_reg};
                    mm_y       = {1'b0, base_reg};
                    state_next = A_AW;
                end
                else
                begin
                    mm_start   = 1'b1;
                    mm_x       = {1'b0, base_reg};
                    mm_y       = {1'b0, base_reg};
                    state_next = A_SW;
                end
            end
            A_AW:
            begin
                if (mm_done)
                begin
                    acc_next   = mm_res;
                    mm_start   = 1'b1;
                    mm_x       = {1'b0, base_reg};
                    mm_y       = {1'b0, base_reg};
                    state_next = A_SW;
                end
            end
            A_SW:
            begin
                if (mm_done)
                begin
                    base_next  = mm_res;
                    y_next     = {1'b0, y_reg[31:1]};
                    state_next = A_LOOP;
                end
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        acc_reg  <= acc_next;
        base_reg <= base_next;
        res_reg  <= res_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.busy   = (state_reg != A_IDLE);
    assign rsp.result = res_reg;
endmodule

>>> rtl/core/modular_combinatorics_engine_top.sv
// Top level of the modular combinatorics engine: sequencer, tables and I/O.
// Each request computes a power, Fermat inverse, factorial, binomial,
// derangement count or Catalan number modulo the configured modulus and
// returns one result. All arithmetic runs through one modular multiplier
// whose reduction is bit-serial. A power takes one product for the base
// reduction plus up to two per exponent bit, and the inverse the same with
// exponent p-2. A factorial or derangement lookup costs two products
// for each new table entry it extends. A binomial adds two cached
// inverse-factorial lookups and two products; each inverse factorial not
// yet cached costs one power. Catalan adds one more power and product.
// Factorials and derangements share one RAM and one fill count; inverse
// factorials with their valid bits live in a second RAM. After reset and
// after every modulus write a clearing pass sweeps the inverse-factorial
// RAM; no request is taken during it. One request is worked at a time;
// the result register lets the next request in while a result still
// waits to be taken.
module modular_combinatorics_engine_top #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic  clk,
    input  logic  rst_n,
    mce_req_if.sink   req,
    mce_rsp_if.source rsp,
    mce_cfg_if.sink   cfg
);
    import mce_pkg::*;

    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int FW   = $clog2(TABLE_DEPTH + 1);
    localparam int HALF = (TABLE_DEPTH + 1) / 2;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_DEC   = 4'd2;
    localparam logic [3:0] ST_EXT   = 4'd3;
    localparam logic [3:0] ST_EXTF  = 4'd4;
    localparam logic [3:0] ST_EXTD  = 4'd5;
    localparam logic [3:0] ST_RDA   = 4'd6;
    localparam logic [3:0] ST_RDAW  = 4'd7;
    localparam logic [3:0] ST_RDB   = 4'd8;
    localparam logic [3:0] ST_RDBW  = 4'd9;
    localparam logic [3:0] ST_INVP  = 4'd10;
    localparam logic [3:0] ST_MULT  = 4'd11;
    localparam logic [3:0] ST_MULW  = 4'd12;
    localparam logic [3:0] ST_CATP  = 4'd13;
    localparam logic [3:0] ST_WFIN  = 4'd14;
    localparam logic [3:0] ST_OUT   = 4'd15;

    // where the table walk returns to
    localparam logic [2:0] PH_TAB = 3'd0;  // plain factorial / derangement
    localparam logic [2:0] PH_FN  = 3'd1;  // n! of a binomial
    localparam logic [2:0] PH_IN  = 3'd2;  // 1/(n-k)!
    localparam logic [2:0] PH_IK  = 3'd3;  // 1/k!
    localparam logic [2:0] PH_CI  = 3'd4;  // Catalan 1/(x+1)

    logic [3:0]    state_reg, state_next;
    logic [2:0]    phase_reg, phase_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [FW-1:0] filled_reg, filled_next;
    logic [30:0]   modulus_reg, modulus_next;
    logic [30:0]   f1_reg, f1_next;
    logic [30:0]   d1_reg, d1_next;
    logic [30:0]   d2_reg, d2_next;
    logic          out_valid_reg, out_valid_next;

    logic [2:0]    cmd_reg, cmd_next;
    logic [31:0]   a_reg, a_next;
    logic [31:0]   b_reg, b_next;
    logic [AW-1:0] n_reg, n_next;
    logic [AW-1:0] k_reg, k_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [30:0]   fnew_reg, fnew_next;
    logic [30:0]   t_reg, t_next;
    logic [30:0]   u_reg, u_next;
    logic [30:0]   val_reg, val_next;
    logic          st_reg, st_next;
    logic [30:0]   value_reg, value_next;
    logic          status_reg, status_next;

    arith_req_t    ar_req;
    arith_rsp_t    ar_rsp;

    logic          a_we;
    logic [AW-1:0] a_waddr;
    logic [61:0]   a_wdata;
    logic [61:0]   a_rdata;
    logic          b_we;
    logic [AW-1:0] b_waddr;
    logic [31:0]   b_wdata;
    logic [31:0]   b_rdata;

    logic [31:0]   pm2;
    logic [31:0]   dsum;
    logic [AW-1:0] dbl;
    logic [30:0]   fact_rd;
    logic [30:0]   der_rd;

    // {derangement, factorial} per index
    mce_ram #(.WIDTH(62), .DEPTH(TABLE_DEPTH)) u_tab_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (idx_reg),
        .rdata (a_rdata)
    );

    // {valid, inverse factorial} per index
    mce_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_inv_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (idx_reg),
        .rdata (b_rdata)
    );

    mce_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .p     (modulus_reg),
        .req   (ar_req),
        .rsp   (ar_rsp)
    );

    assign pm2     = {1'b0, modulus_reg} - 32'd2;
    assign dsum    = {1'b0, d1_reg} + {1'b0, d2_reg};
    assign dbl     = {a_reg[AW-2:0], 1'b0};
    assign fact_rd = a_rdata[30:0];
    assign der_rd  = a_rdata[61:31];

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        clr_next       = clr_reg;
        filled_next    = filled_reg;
        modulus_next   = modulus_reg;
        f1_next        = f1_reg;
        d1_next        = d1_reg;
        d2_next        = d2_reg;
        out_valid_next = out_valid_reg;
        cmd_next       = cmd_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        idx_next       = idx_reg;
        fnew_next      = fnew_reg;
        t_next         = t_reg;
        u_next         = u_reg;
        val_next       = val_reg;
        st_next        = st_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        ar_req         = '0;
        a_we           = 1'b0;
        a_waddr        = filled_reg[AW-1:0];
        a_wdata        = '0;
        b_we           = 1'b0;
        b_waddr        = idx_reg;
        b_wdata        = '0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                // sweep valid bits; seed entries 0 and 1 of the table RAM
                b_we    = 1'b1;
                b_waddr = clr_reg;
                a_we    = (clr_reg < AW'(2));
                a_waddr = clr_reg;
                a_wdata = clr_reg[0] ? {31'd0, 31'd1} : {31'd1, 31'd1};
                if (clr_reg == AW'(TABLE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next   = req.command;
                    a_next     = req.operand_a;
                    b_next     = req.operand_b;
                    state_next = ST_DEC;
                end
            end
            ST_DEC:
            begin
                st_next  = 1'b0;
                val_next = 31'd0;
                unique case (cmd_reg) inside
                    CMD_POW:
                    begin
                        ar_req.start = 1'b1;
                        ar_req.op    = ARITH_POW;
                        ar_req.x     = a_reg;
                        ar_req.y     = b_reg;
                        state_next   = ST_WFIN;
                    end
                    CMD_INV:
                    begin
                        ar_req.start = 1'b1;
                        ar_req.op    = ARITH_POW;
                        ar_req.x     = a_reg;
                        ar_req.y     = pm2;
                        state_next   = ST_WFIN;
                    end
                    CMD_FACT, CMD_DER:
                    begin
                        if (a_reg >= 32'(TABLE_DEPTH))
                        begin
                            st_next    = 1'b1;
                            state_next = ST_OUT;
                        end
                        else
                        begin
                            idx_next   = a_reg[AW-1:0];
                            phase_next = PH_TAB;
                            state_next = ST_EXT;
                        end
                    end
                    CMD_BINOM:
                    begin
                        if (a_reg >= 32'(TABLE_DEPTH))
                        begin
                            st_next    = 1'b1;
                            state_next = ST_OUT;
                        end
                        else if (b_reg > a_reg)
                        begin
                            state_next = ST_OUT;
                        end
                        else
                        begin
                            n_next     = a_reg[AW-1:0];
                            k_next     = b_reg[AW-1:0];
                            idx_next   = a_reg[AW-1:0];
                            phase_next = PH_FN;
                            state_next = ST_EXT;
                        end
                    end
                    CMD_CAT:
                    begin
                        if (a_reg >= 32'(HALF))
                        begin
                            st_next    = 1'b1;
                            state_next = ST_OUT;
                        end
                        else
                        begin
                            n_next     = dbl[AW-1:0];
                            k_next     = a_reg[AW-1:0];
                            idx_next   = dbl[AW-1:0];
                            phase_next = PH_FN;
                            state_next = ST_EXT;
                        end
                    end
                    default:
                    begin
                        state_next = ST_OUT;
                    end
                endcase
            end
            ST_EXT:
            begin
                // extend both tables until the index is covered
                if (FW'(idx_reg) >= filled_reg)
                begin
                    ar_req.start = 1'b1;
                    ar_req.op    = ARITH_MUL;
                    ar_req.x     = {1'b0, f1_reg};
                    ar_req.y     = 32'(filled_reg);
                    state_next   = ST_EXTF;
                end
                else
                begin
                    state_next = ST_RDA;
                end
            end
            ST_EXTF:
            begin
                if (ar_rsp.done)
                begin
                    fnew_next    = ar_rsp.result;
                    ar_req.start = 1'b1;
                    ar_req.op    = ARITH_MUL;
                    ar_req.x     = 32'(filled_reg) - 32'd1;
                    ar_req.y     = dsum;
                    state_next   = ST_EXTD;
                end
            end
            ST_EXTD:
            begin
                if (ar_rsp.done)
                begin
                    a_we        = 1'b1;
                    a_waddr     = filled_reg[AW-1:0];
                    a_wdata     = {ar_rsp.result, fnew_reg};
                    f1_next     = fnew_reg;
                    d2_next     = d1_reg;
                    d1_next     = ar_rsp.result;
                    filled_next = filled_reg + FW'(1);
                    state_next  = ST_EXT;
                end
            end
            ST_RDA:
            begin
                state_next = ST_RDAW;
            end
            ST_RDAW:
            begin
                case (phase_reg)
                    PH_TAB:
                    begin
                        val_next   = (cmd_reg == CMD_DER) ? der_rd : fact_rd;
                        state_next = ST_OUT;
                    end
                    PH_FN:
                    begin
                        t_next     = fact_rd;
                        idx_next   = n_reg - k_reg;
                        phase_next = PH_IN;
                        state_next = ST_RDB;
                    end
                    default:
                    begin
                        // inverse factorial miss
                        ar_req.start = 1'b1;
                        ar_req.op    = ARITH_POW;
                        ar_req.x     = {1'b0, fact_rd};
                        ar_req.y     = pm2;
                        state_next   = ST_INVP;
                    end
                endcase
            end
            ST_RDB:
            begin
                state_next = ST_RDBW;
            end
            ST_RDBW:
            begin
                if (b_rdata[31])
                begin
                    u_next     = b_rdata[30:0];
                    state_next = ST_MULT;
                end
                else
                begin
                    state_next = ST_EXT;
                end
            end
            ST_INVP:
            begin
                if (ar_rsp.done)
                begin
                    b_we       = 1'b1;
                    b_waddr    = idx_reg;
                    b_wdata    = {1'b1, ar_rsp.result};
                    u_next     = ar_rsp.result;
                    state_next = ST_MULT;
                end
            end
            ST_MULT:
            begin
                ar_req.start = 1'b1;
                ar_req.op    = ARITH_MUL;
                ar_req.x     = {1'b0, t_reg};
                ar_req.y     = {1'b0, u_reg};
                state_next   = ST_MULW;
            end
            ST_MULW:
            begin
                if (ar_rsp.done)
                begin
                    t_next = ar_rsp.result;
                    case (phase_reg)
                        PH_IN:
                        begin
                            idx_next   = k_reg;
                            phase_next = PH_IK;
                            state_next = ST_RDB;
                        end
                        PH_IK:
                        begin
                            if (cmd_reg == CMD_CAT)
                            begin
                                ar_req.start = 1'b1;
                                ar_req.op    = ARITH_POW;
                                ar_req.x     = a_reg + 32'd1;
                                ar_req.y     = pm2;
                                phase_next   = PH_CI;
                                state_next   = ST_CATP;
                            end
                            else
                            begin
                                val_next   = ar_rsp.result;
                                state_next = ST_OUT;
                            end
                        end
                        default:
                        begin
                            val_next   = ar_rsp.result;
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_CATP:
            begin
                if (ar_rsp.done)
                begin
                    u_next     = ar_rsp.result;
                    state_next = ST_MULT;
                end
            end
            ST_WFIN:
            begin
                if (ar_rsp.done)
                begin
                    val_next   = ar_rsp.result;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    value_next     = (modulus_reg < 31'd2 || st_reg) ? 31'd0 : val_reg;
                    status_next    = st_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // modulus write: drop the fill count, restart the clearing pass
        if (cfg.valid)
        begin
            modulus_next = cfg.data;
            filled_next  = FW'(2);
            f1_next      = 31'd1;
            d1_next      = 31'd0;
            d2_next      = 31'd1;
            clr_next     = '0;
            state_next   = ST_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            phase_reg     <= PH_TAB;
            clr_reg       <= '0;
            filled_reg    <= FW'(2);
            modulus_reg   <= 31'd1000000007;
            f1_reg        <= 31'd1;
            d1_reg        <= 31'd0;
            d2_reg        <= 31'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            clr_reg       <= clr_next;
            filled_reg    <= filled_next;
            modulus_reg   <= modulus_next;
            f1_reg        <= f1_next;
            d1_reg        <= d1_next;
            d2_reg        <= d2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        n_reg      <= n_next;
        k_reg      <= k_next;
        idx_reg    <= idx_next;
        fnew_reg   <= fnew_next;
        t_reg      <= t_next;
        u_reg      <= u_next;
        val_reg    <= val_next;
        st_reg     <= st_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    assign req.ready  = (state_reg == ST_IDLE);
    assign cfg.ready  = 1'b1;
    assign rsp.valid  = out_valid_reg;
    assign rsp.value  = value_reg;
    assign rsp.status = status_reg;

    // arithmetic unit is only started when free
    a_arith_free: assert property (@(posedge clk) disable iff (!rst_n)
        ar_req.start |-> !ar_rsp.busy)
        else $error("arith started while busy");

    // fill count stays within the table
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg >= FW'(2) && filled_reg <= FW'(TABLE_DEPTH))
        else $error("fill count out of range");

    // modulus write restarts clearing with fresh fill count
    a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.valid |=> state_reg == ST_CLEAR && filled_reg == FW'(2))
        else $error("modulus write did not reset tables");
endmodule
